// ===== rtl/core/a64br_pkg.sv =====
// Shared types and encoding constants for the AArch64 branch classifier.
package a64br_pkg;

    localparam int unsigned INSTR_W = 32;
    localparam int unsigned KIND_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_UNCOND   = 3'd1,
        KIND_CALL     = 3'd2,
        KIND_COND     = 3'd3,
        KIND_BARRIER  = 3'd4,
        KIND_INDIRECT = 3'd5,
        KIND_INDCALL  = 3'd6,
        KIND_RETURN   = 3'd7
    } t_kind;

    typedef logic [INSTR_W-1:0] t_word;

    // Major group, bits 31:25
    localparam logic [6:0] GRP_B_0   = 7'h0a;
    localparam logic [6:0] GRP_B_1   = 7'h0b;
    localparam logic [6:0] GRP_BL_0  = 7'h4a;
    localparam logic [6:0] GRP_BL_1  = 7'h4b;
    localparam logic [6:0] GRP_CB_0  = 7'h1a;
    localparam logic [6:0] GRP_CB_1  = 7'h5a;
    localparam logic [6:0] GRP_TB_0  = 7'h1b;
    localparam logic [6:0] GRP_TB_1  = 7'h5b;
    localparam logic [6:0] GRP_BCOND = 7'h2a;
    localparam logic [6:0] GRP_SYS   = 7'h6a;
    localparam logic [6:0] GRP_BREG  = 7'h6b;

    // B.cond: conditions at or above this act as always
    localparam logic [3:0] COND_AL = 4'h e;

    // System space barrier fields
    localparam logic [4:0] REG_ZR          = 5'h1f;
    localparam logic [3:0] SYS_CRN_BARRIER = 4'd3;
    localparam logic [2:0] SYS_OP1_BARRIER = 3'd3;
    localparam logic [2:0] SYS_OP2_ISB     = 3'd6;
    localparam logic [2:0] SYS_OP2_SB      = 3'd7;

    // Branch-register group opc codes
    localparam logic [3:0] BREG_OPC_BR   = 4'd0;
    localparam logic [3:0] BREG_OPC_BLR  = 4'd1;
    localparam logic [3:0] BREG_OPC_RET  = 4'd2;
    localparam logic [3:0] BREG_OPC_ERET = 4'd4;

endpackage

// ===== rtl/core/a64br_instr_if.sv =====
// Instruction word channel: valid/ready handshake with one 32-bit word per beat.
interface a64br_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

// ===== rtl/core/a64br_kind_if.sv =====
// Branch class channel: valid/ready handshake with the class of one word per beat.
interface a64br_kind_if;
    logic       valid;
    logic       ready;
    logic [2:0] branch_kind;
    logic       is_branch;

    modport source (output valid, output branch_kind, output is_branch, input ready);
    modport sink   (input valid, input branch_kind, input is_branch, output ready);
endinterface

// ===== rtl/core/a64br_decode.sv =====
// Combinational branch class decode of one AArch64 instruction word.
module a64br_decode
    import a64br_pkg::*;
(
    input  t_word i_word,
    output t_kind o_kind
);

    t_kind sys_kind;
    t_kind breg_kind;

    // ISB always, SB only with CRm zero; everything else in system space is none
    always_comb begin
        sys_kind = KIND_NONE;
        if (i_word[20:19] == 2'd0 && !i_word[21] && i_word[4:0] == REG_ZR
            && i_word[15:12] == SYS_CRN_BARRIER && i_word[18:16] == SYS_OP1_BARRIER) begin
            if (i_word[7:5] == SYS_OP2_ISB) begin
                sys_kind = KIND_BARRIER;
            end else if (i_word[7:5] == SYS_OP2_SB && i_word[11:8] == 4'd0) begin
                sys_kind = KIND_BARRIER;
            end
        end
    end

    // Pointer-auth forms fail the op2/op3/op4 checks and drop to none
    always_comb begin
        breg_kind = KIND_NONE;
        if (i_word[20:16] == REG_ZR && i_word[15:10] == 6'd0 && i_word[4:0] == 5'd0) begin
            case (i_word[24:21])
                BREG_OPC_BR:   breg_kind = KIND_INDIRECT;
                BREG_OPC_BLR:  breg_kind = KIND_INDCALL;
                BREG_OPC_RET:  breg_kind = KIND_RETURN;
                BREG_OPC_ERET: breg_kind = KIND_RETURN;
                default:       breg_kind = KIND_NONE;
            endcase
        end
    end

    always_comb begin
        case (i_word[31:25])
            GRP_B_0, GRP_B_1:                     o_kind = KIND_UNCOND;
            GRP_BL_0, GRP_BL_1:                   o_kind = KIND_CALL;
            GRP_CB_0, GRP_CB_1, GRP_TB_0, GRP_TB_1: o_kind = KIND_COND;
            GRP_BCOND: begin
                if (i_word[4] || i_word[24]) begin
                    o_kind = KIND_NONE;
                end else if (i_word[3:0] < COND_AL) begin
                    o_kind = KIND_COND;
                end else begin
                    o_kind = KIND_UNCOND;
                end
            end
            GRP_SYS: begin
                if (i_word[24] && i_word[23:22] == 2'd0) begin
                    o_kind = sys_kind;
                end else begin
                    o_kind = KIND_NONE;
                end
            end
            GRP_BREG: o_kind = breg_kind;
            default:  o_kind = KIND_NONE;
        endcase
    end

endmodule

// ===== rtl/core/aarch64_branch_classifier_top.sv =====
// Top level of the AArch64 branch classifier: input stage, decode, result stage.
//
//   channel   | dir | payload                         | handshake
//   i_instr   | in  | instr_word[31:0]                | valid/ready
//   o_kind    | out | branch_kind[2:0], is_branch     | valid/ready
//
// One word per cycle while o_kind is not stalled; a word passes through the
// input register and then the result register before it appears as a result.
// Synchronous active-low reset clears both stage valid flags only.
// A stall on o_kind holds the result; the input stage keeps taking a beat
// while the result register frees up in the same cycle.
module aarch64_branch_classifier_top
    import a64br_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    a64br_instr_if.sink     i_instr,
    a64br_kind_if.source    o_kind
);

    logic  r_s1_valid;
    t_word r_s1_word;
    logic  r_out_valid;
    t_kind r_out_kind;

    logic  n_s1_valid;
    logic  n_out_valid;
    t_kind dec_kind;
    logic  out_ready;
    logic  s1_ready;

    a64br_decode u_decode (
        .i_word (r_s1_word),
        .o_kind (dec_kind)
    );

    assign out_ready      = !r_out_valid || o_kind.ready;
    assign s1_ready       = !r_s1_valid || out_ready;
    assign i_instr.ready  = s1_ready;

    // Advance each stage when the one ahead can take it
    assign n_s1_valid  = s1_ready ? i_instr.valid : r_s1_valid;
    assign n_out_valid = out_ready ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_instr.valid) begin
            r_s1_word <= i_instr.instr_word;
        end
        if (out_ready && r_s1_valid) begin
            r_out_kind <= dec_kind;
        end
    end

    assign o_kind.valid       = r_out_valid;
    assign o_kind.branch_kind = r_out_kind;
    assign o_kind.is_branch   = (r_out_kind != KIND_NONE);

endmodule
